// File: rtl/aes128_pkg.sv
// Package: AES-128 types, S-box and round helper functions.
`default_nettype none
package aes128_pkg;

  typedef logic [127:0] blk_t;
  typedef logic [7:0] byte_t;

  localparam int NumRounds = 10;
  localparam logic [1:0] CfgKeyHi = 2'd0;
  localparam logic [1:0] CfgKeyLo = 2'd1;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // byte i of a block sits in bits [127-8i -: 8]
  function automatic byte_t get_b(blk_t b, int i);
    get_b = b[127 - 8*i -: 8];
  endfunction

  function automatic byte_t xtime(byte_t v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t sub_shift(blk_t s);
    blk_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = SBOX[get_b(s, r + 4*((c + r) % 4))];
      end
    end
    sub_shift = t;
  endfunction

  function automatic blk_t mix_cols(blk_t s);
    blk_t t;
    byte_t a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(s, 4*c);
      a1 = get_b(s, 4*c + 1);
      a2 = get_b(s, 4*c + 2);
      a3 = get_b(s, 4*c + 3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 8]  = a0 ^ al ^ xtime(a0 ^ a1);
      t[119 - 32*c -: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      t[111 - 32*c -: 8]  = a2 ^ al ^ xtime(a2 ^ a3);
      t[103 - 32*c -: 8]  = a3 ^ al ^ xtime(a3 ^ a0);
    end
    mix_cols = t;
  endfunction

  function automatic blk_t next_key(blk_t k, byte_t rcon);
    logic [31:0] w0, w1, w2, w3, tw;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    tw = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ tw;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

// File: rtl/aes128_block_encrypt_core.sv
// Top level: AES-128 encryption, key registers and an unrolled round pipeline.
//   channel | ports                                      | dir
//   in      | in_valid in_stall in_plaintext_hi/lo       | item in
//   out     | out_valid out_stall out_ciphertext_hi/lo   | result out
//   cfg     | cfg_we cfg_index cfg_data                  | key write
// An input AddRoundKey stage and ten round stages.
// One transaction per cycle when out_stall is low.
// A stall freezes the whole pipeline; in_stall follows out_stall only when
// the last stage holds a valid result, so empty slots keep filling.
// Reset (synchronous, rst_n low) clears the valid bits and the key.
`default_nettype none
module aes128_block_encrypt_core import aes128_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_plaintext_hi,
  input  wire logic [63:0] in_plaintext_lo,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_ciphertext_hi,
  output logic [63:0]      out_ciphertext_lo,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam logic [7:0] RCONS [NumRounds] =
    '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  logic [63:0] key_hi_r, key_lo_r;
  logic adv, vld0_r;
  blk_t st0_r, key0_r;
  logic vld [NumRounds+1];
  blk_t st [NumRounds+1];
  blk_t key [NumRounds+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_we) begin
      unique case ({1'b0, cfg_index})
        CfgKeyHi: key_hi_r <= cfg_data;
        CfgKeyLo: key_lo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv = !(vld[NumRounds] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st0_r <= {in_plaintext_hi, in_plaintext_lo} ^ {key_hi_r, key_lo_r};
      key0_r <= {key_hi_r, key_lo_r};
    end
  end

  assign vld[0] = vld0_r;
  assign st[0] = st0_r;
  assign key[0] = key0_r;

  for (genvar g = 0; g < NumRounds; g++) begin : g_rnd
    aes128_round #(.RCON(RCONS[g]), .LAST(g == NumRounds - 1)) u_rnd (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .vld_i(vld[g]), .st_i(st[g]), .key_i(key[g]),
      .vld_o(vld[g+1]), .st_o(st[g+1]), .key_o(key[g+1])
    );
  end

  assign out_valid = vld[NumRounds];
  assign out_ciphertext_hi = st[NumRounds][127:64];
  assign out_ciphertext_lo = st[NumRounds][63:0];

endmodule
`default_nettype wire

// File: rtl/aes128_round.sv
// One registered AES round stage: state and round key advance together.
`default_nettype none
module aes128_round import aes128_pkg::*; #(
  parameter logic [7:0] RCON = 8'h01,
  parameter bit LAST = 1'b0
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic adv,
  input  wire logic vld_i,
  input  wire blk_t st_i,
  input  wire blk_t key_i,
  output logic      vld_o,
  output blk_t      st_o,
  output blk_t      key_o
);

  logic vld_r;
  blk_t st_r, key_r, st_nxt, key_nxt, ss;

  always_comb begin
    key_nxt = next_key(key_i, RCON);
    ss = sub_shift(st_i);
    st_nxt = (LAST ? ss : mix_cols(ss)) ^ key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
      key_r <= key_nxt;
    end
  end

  assign vld_o = vld_r;
  assign st_o = st_r;
  assign key_o = key_r;

endmodule
`default_nettype wire
